// ===== rtl/nps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants for the nearest point search block
// Payload structs, the distance chain token, op codes and controller states.
// ----------------------------------------------------------------------------
package nps_pkg;

  // field widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned AXES    = 3;
  localparam int unsigned DIST_W  = 2 * COORD_W + 2;
  localparam int unsigned NIDX_W  = 8;
  localparam int unsigned NP_W    = 9;

  // register port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-1:0] ADDR_NUM_POINTS = APB_AW'(0);

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  // element 0 is x, 1 is y, 2 is z
  typedef coord_t [AXES-1:0] coord_vec_t;

  // input item
  typedef struct packed {
    logic               operation;
    logic [NIDX_W-1:0]  point_index;
    coord_t             coord_x;
    coord_t             coord_y;
    coord_t             coord_z;
  } nps_cmd_t;

  // result item
  typedef struct packed {
    logic [NIDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0]  min_distance_sq;
    logic               found;
  } nps_res_t;

  // token travelling down the distance chain
  typedef struct packed {
    logic               valid;
    logic               last;
    coord_vec_t         coords;
    logic [DIST_W-1:0]  sum;
  } nps_tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PUSH
  } nps_state_e;

endpackage
`default_nettype wire

// ===== rtl/nps_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nps_cell: one axis of the distance chain
// Holds one query coordinate, squares its distance to the coordinate at the
// head of the token and adds it to the partial sum. The coordinates rotate by
// one place so the next cell finds its axis at the head.
// ----------------------------------------------------------------------------
module nps_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire nps_pkg::coord_t   qcoord_i,
  input  wire nps_pkg::nps_tok_t tok_i,
  output nps_pkg::nps_tok_t      tok_o
);
  import nps_pkg::*;

  coord_t                qcoord_q;
  logic [COORD_W:0]      dif;
  logic [COORD_W:0]      mag;
  logic [COORD_W-1:0]    diff_q;
  logic [2*COORD_W-1:0]  sq;
  nps_tok_t              tok_rot;
  nps_tok_t              tok_a_q;
  nps_tok_t              tok_b_d;
  nps_tok_t              tok_b_q;

  // query coordinate for this axis
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      qcoord_q <= qcoord_i;
    end
  end

  // absolute difference, magnitude fits in COORD_W bits
  assign dif = {qcoord_q[COORD_W-1], qcoord_q} - {tok_i.coords[0][COORD_W-1], tok_i.coords[0]};
  assign mag = dif[COORD_W] ? (~dif + 1'b1) : dif;

  // rotate so the next axis sits at the head
  always_comb begin
    tok_rot        = tok_i;
    tok_rot.coords = {tok_i.coords[0], tok_i.coords[AXES-1:1]};
  end

  // stage a: difference
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_a_q <= '0;
    end else begin
      tok_a_q <= tok_rot;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= mag[COORD_W-1:0];
  end

  // stage b: square and accumulate
  assign sq = diff_q * diff_q;

  always_comb begin
    tok_b_d     = tok_a_q;
    tok_b_d.sum = tok_a_q.sum + DIST_W'(sq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_b_q <= '0;
    end else begin
      tok_b_q <= tok_b_d;
    end
  end

  assign tok_o = tok_b_q;

endmodule
`default_nettype wire

// ===== rtl/nps_best.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nps_best: running minimum at the end of the distance chain
// Numbers the tokens in arrival order and keeps the first smallest sum.
// ----------------------------------------------------------------------------
module nps_best #(
  parameter int unsigned IDX_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire nps_pkg::nps_tok_t tok_i,
  output logic                   done_o,
  output logic [IDX_W-1:0]       best_idx_o,
  output logic [nps_pkg::DIST_W-1:0] best_dist_o,
  output logic                   found_o
);
  import nps_pkg::*;

  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [DIST_W-1:0] best_dist_q;
  logic              found_q;
  logic              done_q;
  logic              take;

  // strict compare keeps the lowest index on a tie
  assign take = tok_i.valid && (!found_q || (tok_i.sum < best_dist_q));

  // entry counter and found flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= tok_i.valid && tok_i.last;
      if (start_i) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (tok_i.valid) begin
        idx_q   <= idx_q + 1'b1;
        found_q <= 1'b1;
      end
    end
  end

  // best so far
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      best_idx_q  <= '0;
      best_dist_q <= '0;
    end else if (take) begin
      best_idx_q  <= idx_q;
      best_dist_q <= tok_i.sum;
    end
  end

  assign done_o      = done_q;
  assign best_idx_o  = best_idx_q;
  assign best_dist_o = best_dist_q;
  assign found_o     = found_q;

endmodule
`default_nettype wire

// ===== rtl/nearest_point_search_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_point_search_top: nearest stored 3D point search
// Point table, scan controller, three-cell distance chain and result register.
// ----------------------------------------------------------------------------
// A write transfer stores one Q8.8 point. A query transfer scans entries 0 to
// num_points-1 (capped at MAX_POINTS): one stored point leaves the point
// memory per cycle and runs down a chain of three axis cells, then a
// running-minimum stage; an empty table answers with found low. One query is
// in flight at a time; the next item is taken as soon as the scan has handed
// its result to the output register, even if that result has not been taken
// yet. Entries must be written before any scan reaches them. num_points must
// be written only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module nearest_point_search_top #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // item input
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire nps_pkg::nps_cmd_t            in_data_i,
  // result output
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output nps_pkg::nps_res_t                 out_data_o,
  // register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [nps_pkg::APB_AW-1:0]   paddr,
  input  wire logic [nps_pkg::APB_DW-1:0]   pwdata,
  output logic [nps_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);
  import nps_pkg::*;

  localparam int unsigned AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned CMP_W = (CNT_W > NP_W) ? CNT_W : NP_W;

  nps_state_e        state_q, state_d;
  logic [NP_W-1:0]   num_points_q;
  logic [CMP_W-1:0]  count;
  logic [CMP_W-1:0]  rd_cnt_q;
  logic              issue_last;
  logic              in_xfer;
  logic              is_query;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  coord_vec_t        in_vec;
  coord_vec_t        mem_q [MAX_POINTS];
  coord_vec_t        rd_data_q;
  logic              rd_vld_q;
  logic              rd_last_q;
  logic              issue;
  logic              out_load;
  logic              out_valid_q;
  nps_res_t          out_data_q;
  nps_tok_t          chain [AXES+1];
  logic              best_done;
  logic [AW-1:0]     best_idx;
  logic [DIST_W-1:0] best_dist;
  logic              best_found;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_NUM_POINTS)) begin
      num_points_q <= pwdata[NP_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_NUM_POINTS) ? APB_DW'(num_points_q) : '0;

  // effective scan length, capped at the table size
  assign count = (CMP_W'(num_points_q) > CMP_W'(MAX_POINTS)) ? CMP_W'(MAX_POINTS)
                                                             : CMP_W'(num_points_q);

  // input decode
  assign in_xfer  = in_valid_i && in_ready_o;
  assign is_query = (in_data_i.operation == OP_QUERY);
  assign in_vec   = {in_data_i.coord_z, in_data_i.coord_y, in_data_i.coord_x};
  assign wr_addr  = AW'(in_data_i.point_index);
  assign wr_en    = in_xfer && (in_data_i.operation == OP_WRITE) &&
                    (32'(in_data_i.point_index) < MAX_POINTS);

  // point memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= in_vec;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_cnt_q[AW-1:0]];
  end

  // scan counter
  assign issue_last = ((rd_cnt_q + CMP_W'(1)) == count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q  <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      rd_vld_q  <= issue;
      rd_last_q <= issue && issue_last;
      if (in_xfer) begin
        rd_cnt_q <= '0;
      end else if (issue) begin
        rd_cnt_q <= rd_cnt_q + CMP_W'(1);
      end
    end
  end

  // controller: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && is_query) begin
          state_d = (count == '0) ? ST_PUSH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (best_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // controller: outputs
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_SCAN:  issue      = 1'b1;
      ST_DRAIN: ;
      ST_PUSH:  out_load   = !out_valid_q || out_ready_i;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // distance chain
  always_comb begin
    chain[0]        = '0;
    chain[0].valid  = rd_vld_q;
    chain[0].last   = rd_last_q;
    chain[0].coords = rd_data_q;
  end

  for (genvar k = 0; k < AXES; k++) begin : g_cell
    nps_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (in_xfer && is_query),
      .qcoord_i (in_vec[k]),
      .tok_i    (chain[k]),
      .tok_o    (chain[k+1])
    );
  end

  // running minimum
  nps_best #(
    .IDX_W (AW)
  ) u_best (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer && is_query),
    .tok_i       (chain[AXES]),
    .done_o      (best_done),
    .best_idx_o  (best_idx),
    .best_dist_o (best_dist),
    .found_o     (best_found)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.nearest_index   <= NIDX_W'(best_idx);
      out_data_q.min_distance_sq <= best_dist;
      out_data_q.found           <= best_found;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // the minimum stage finishes only while the controller waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_done |-> (state_q == ST_DRAIN))
    else $error("scan finished outside drain");

  // the scan never reads past the effective count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rd_cnt_q < count))
    else $error("scan address beyond count");

  // an empty table goes straight to the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && is_query && (count == '0)) |=> (state_q == ST_PUSH))
    else $error("empty query did not go to push");

  // a result without a point carries zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |->
      ((out_data_o.nearest_index == '0) && (out_data_o.min_distance_sq == '0)))
    else $error("empty result not zero");

endmodule
`default_nettype wire
